/* rtl/i2cm_pkg.sv */
// Shared types, codes and constants for the I2C master bit engine.
package i2cm_pkg;

    localparam int CMD_W  = 3;
    localparam int CFG_W  = 16;
    localparam int BYTE_W = 8;
    localparam int BIT_W  = 3;

    localparam logic [BIT_W-1:0] BYTE_MSB    = 3'd7;
    localparam logic [CFG_W-1:0] DELAY_RESET = 16'd10;

    // command codes on the tick channel
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    // classified command
    typedef enum logic [4:0] {
        K_NONE  = 5'b00001,
        K_START = 5'b00010,
        K_STOP  = 5'b00100,
        K_WRITE = 5'b01000,
        K_READ  = 5'b10000
    } t_kind;

    // one classified tick as it sits in the queue
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_nack;
        logic              sda_in;
    } t_tick;

    // queue head seen by the sequencer
    typedef struct packed {
        logic  valid;
        t_tick item;
    } t_head;

    // one result beat
    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_enable;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_seen;
    } t_result;

    // line sequencer phases
    typedef enum logic [15:0] {
        PH_IDLE    = 16'h0001,
        PH_ST_A    = 16'h0002,
        PH_ST_B    = 16'h0004,
        PH_SP_A    = 16'h0008,
        PH_WR_HI   = 16'h0010,
        PH_WR_LO   = 16'h0020,
        PH_WR_NEXT = 16'h0040,
        PH_AK_HI   = 16'h0080,
        PH_AK_SMP  = 16'h0100,
        PH_AK_END  = 16'h0200,
        PH_RD_HI   = 16'h0400,
        PH_RD_SMP  = 16'h0800,
        PH_RD_NEXT = 16'h1000,
        PH_RA_HI   = 16'h2000,
        PH_RA_LO   = 16'h4000,
        PH_RA_END  = 16'h8000
    } t_phase;

    // map a raw command code to its class; unknown codes act as none
    function automatic t_kind classify(input logic [CMD_W-1:0] cmd);
        t_kind k;
        unique case (cmd)
            CMD_NONE:  k = K_NONE;
            CMD_START: k = K_START;
            CMD_STOP:  k = K_STOP;
            CMD_WRITE: k = K_WRITE;
            CMD_READ:  k = K_READ;
            default:   k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

/* rtl/i2cm_tick_if.sv */
// Tick channel: one beat per time tick, carrying command and sampled SDA.
interface i2cm_tick_if;
    logic                            valid;
    logic                            ready;
    logic [i2cm_pkg::CMD_W-1:0]      cmd;
    logic [i2cm_pkg::BYTE_W-1:0]     tx_byte;
    logic                            send_nack;
    logic                            sda_in;

    modport source (output valid, cmd, tx_byte, send_nack, sda_in, input ready);
    modport sink   (input valid, cmd, tx_byte, send_nack, sda_in, output ready);
endinterface

/* rtl/i2cm_res_if.sv */
// Result channel: line levels and status after each tick.
interface i2cm_res_if;
    logic                            valid;
    logic                            ready;
    logic                            scl_level;
    logic                            sda_level;
    logic                            sda_enable;
    logic                            busy_res;
    logic                            done_res;
    logic [i2cm_pkg::BYTE_W-1:0]     rx_byte;
    logic                            ack_seen;

    modport source (output valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                    rx_byte, ack_seen, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                    rx_byte, ack_seen, output ready);
endinterface

/* rtl/i2cm_front.sv */
// Front end: accepts tick beats, classifies the command and queues them.
module i2cm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2cm_tick_if.sink         i_tick,
    output i2cm_pkg::t_head   o_head,
    input  logic              i_pop
);

    localparam int DEPTH = 2;

    i2cm_pkg::t_tick r_mem [DEPTH];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic            w_push;

    // room while fewer than two beats are held
    assign i_tick.ready = (r_count != 2'(DEPTH));
    assign w_push       = i_tick.valid && i_tick.ready;

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rptr];

    // storage write with classification on the way in
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr].kind      <= i2cm_pkg::classify(i_tick.cmd);
            r_mem[r_wptr].tx_byte   <= i_tick.tx_byte;
            r_mem[r_wptr].send_nack <= i_tick.send_nack;
            r_mem[r_wptr].sda_in    <= i_tick.sda_in;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/i2cm_back.sv */
// Back end: I2C line sequencer stepping once per queued tick, with result register.
module i2cm_back #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [i2cm_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  i2cm_pkg::t_head              i_head,
    output logic                         o_pop,
    i2cm_res_if.source                   o_res
);

    // configuration
    logic [DELAY_WIDTH-1:0]          r_delay_ticks;

    // sequencer state
    i2cm_pkg::t_phase                r_phase,     n_phase;
    logic [i2cm_pkg::BIT_W-1:0]      r_bit_idx,   n_bit_idx;
    logic [DELAY_WIDTH-1:0]          r_delay_cnt, n_delay_cnt;
    logic [i2cm_pkg::BYTE_W-1:0]     r_shift,     n_shift;
    logic                            r_nack,      n_nack;
    logic                            r_scl,       n_scl;
    logic                            r_sda,       n_sda;
    logic                            r_sda_oe,    n_sda_oe;
    logic                            r_ack,       n_ack;
    logic [i2cm_pkg::BYTE_W-1:0]     r_rx_hold,   n_rx_hold;
    logic                            n_done;

    // result register
    logic                            r_out_valid;
    i2cm_pkg::t_result               r_res;

    logic [DELAY_WIDTH-1:0]          w_load;
    i2cm_pkg::t_tick                 w_item;

    assign w_item = i_head.item;
    assign o_pop  = i_head.valid && (!r_out_valid || o_res.ready);
    // zero delay behaves as one tick
    assign w_load = (r_delay_ticks == '0) ? DELAY_WIDTH'(1) : r_delay_ticks;

    // delay register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= DELAY_WIDTH'(i2cm_pkg::DELAY_RESET);
        end else if (i_cfg_we) begin
            r_delay_ticks <= DELAY_WIDTH'(i_cfg_wdata);
        end
    end

    // next state for one tick
    always_comb begin
        n_phase     = r_phase;
        n_bit_idx   = r_bit_idx;
        n_delay_cnt = r_delay_cnt;
        n_shift     = r_shift;
        n_nack      = r_nack;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_sda_oe    = r_sda_oe;
        n_ack       = r_ack;
        n_rx_hold   = r_rx_hold;
        n_done      = 1'b0;

        if (r_phase == i2cm_pkg::PH_IDLE) begin
            // launch a new command
            unique case (w_item.kind)
                i2cm_pkg::K_START: begin
                    n_sda_oe = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                    n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_ST_A;
                end
                i2cm_pkg::K_STOP: begin
                    n_sda_oe = 1'b1; n_sda = 1'b0; n_scl = 1'b1;
                    n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_SP_A;
                end
                i2cm_pkg::K_WRITE: begin
                    n_shift   = w_item.tx_byte;
                    n_bit_idx = i2cm_pkg::BYTE_MSB;
                    n_sda_oe  = 1'b1;
                    n_sda     = w_item.tx_byte[i2cm_pkg::BYTE_MSB];
                    n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_WR_HI;
                end
                i2cm_pkg::K_READ: begin
                    n_shift   = '0;
                    n_bit_idx = i2cm_pkg::BYTE_MSB;
                    n_nack    = w_item.send_nack;
                    n_sda_oe  = 1'b0;
                    n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_RD_HI;
                end
                default: ;
            endcase
        end else if (r_delay_cnt > DELAY_WIDTH'(1)) begin
            n_delay_cnt = r_delay_cnt - DELAY_WIDTH'(1);
        end else begin
            // delay expired: move the lines on
            unique case (r_phase)
                i2cm_pkg::PH_ST_A: begin
                    n_sda = 1'b0; n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_ST_B;
                end
                i2cm_pkg::PH_ST_B: begin
                    n_scl = 1'b0; n_done = 1'b1;
                end
                i2cm_pkg::PH_SP_A: begin
                    n_sda = 1'b1; n_done = 1'b1;
                end
                i2cm_pkg::PH_WR_HI: begin
                    n_scl = 1'b1; n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_WR_LO;
                end
                i2cm_pkg::PH_WR_LO: begin
                    n_scl = 1'b0; n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_WR_NEXT;
                end
                i2cm_pkg::PH_WR_NEXT: begin
                    if (r_bit_idx != '0) begin
                        n_bit_idx = r_bit_idx - 3'd1;
                        n_sda     = r_shift[n_bit_idx];
                        n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_WR_HI;
                    end else begin
                        n_sda_oe = 1'b0;
                        n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_AK_HI;
                    end
                end
                i2cm_pkg::PH_AK_HI: begin
                    n_scl = 1'b1; n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_AK_SMP;
                end
                i2cm_pkg::PH_AK_SMP: begin
                    n_ack = ~w_item.sda_in;
                    n_scl = 1'b0;
                    n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_AK_END;
                end
                i2cm_pkg::PH_AK_END: begin
                    n_sda_oe = 1'b1; n_done = 1'b1;
                end
                i2cm_pkg::PH_RD_HI: begin
                    n_scl = 1'b1; n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_RD_SMP;
                end
                i2cm_pkg::PH_RD_SMP: begin
                    n_shift[r_bit_idx] = r_shift[r_bit_idx] | w_item.sda_in;
                    n_scl = 1'b0;
                    n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_RD_NEXT;
                end
                i2cm_pkg::PH_RD_NEXT: begin
                    if (r_bit_idx != '0) begin
                        n_bit_idx = r_bit_idx - 3'd1;
                        n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_RD_HI;
                    end else begin
                        n_sda_oe = 1'b1;
                        n_sda    = r_nack;
                        n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_RA_HI;
                    end
                end
                i2cm_pkg::PH_RA_HI: begin
                    n_scl = 1'b1; n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_RA_LO;
                end
                i2cm_pkg::PH_RA_LO: begin
                    n_scl = 1'b0; n_delay_cnt = w_load; n_phase = i2cm_pkg::PH_RA_END;
                end
                default: begin
                    // end of read: publish the byte
                    n_rx_hold = r_shift;
                    n_done    = 1'b1;
                end
            endcase
            if (n_done) begin
                n_phase     = i2cm_pkg::PH_IDLE;
                n_delay_cnt = '0;
            end
        end
    end

    // sequencer state, advanced once per popped tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cm_pkg::PH_IDLE;
            r_bit_idx   <= '0;
            r_delay_cnt <= '0;
            r_shift     <= '0;
            r_nack      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_sda_oe    <= 1'b1;
            r_ack       <= 1'b0;
            r_rx_hold   <= '0;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_bit_idx   <= n_bit_idx;
            r_delay_cnt <= n_delay_cnt;
            r_shift     <= n_shift;
            r_nack      <= n_nack;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_sda_oe    <= n_sda_oe;
            r_ack       <= n_ack;
            r_rx_hold   <= n_rx_hold;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.scl_level  <= n_scl;
            r_res.sda_level  <= n_sda;
            r_res.sda_enable <= n_sda_oe;
            r_res.busy_res   <= (n_phase != i2cm_pkg::PH_IDLE);
            r_res.done_res   <= n_done;
            r_res.rx_byte    <= n_rx_hold;
            r_res.ack_seen   <= n_ack;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.scl_level  = r_res.scl_level;
    assign o_res.sda_level  = r_res.sda_level;
    assign o_res.sda_enable = r_res.sda_enable;
    assign o_res.busy_res   = r_res.busy_res;
    assign o_res.done_res   = r_res.done_res;
    assign o_res.rx_byte    = r_res.rx_byte;
    assign o_res.ack_seen   = r_res.ack_seen;

endmodule

/* rtl/i2c_master_bit_engine.sv */
// Path: an accepted tick beat is written into the two-beat queue; the sequencer pops it and
// registers its result beat. Throughput: one tick beat per cycle while results are taken;
// the queue between the classifier and the sequencer plus the result register let either side
// stall without losing a beat. Reset: synchronous active-low; lines come up driven high,
// sequencer idle, delay register at 10 ticks. No clearing pass is needed after reset.
module i2c_master_bit_engine #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [i2cm_pkg::CFG_W-1:0]   i_cfg_wdata,
    i2cm_tick_if.sink                    i_tick,
    i2cm_res_if.source                   o_res
);

    i2cm_pkg::t_head w_head;
    logic            w_pop;

    // classify and queue
    i2cm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (i_tick),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // line sequencer
    i2cm_back #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

endmodule
